@@ rtl/swpp_pkg.sv @@
package swpp_pkg;

  localparam int WINDOW      = 11;
  localparam int MIDDLE      = 5;
  localparam int PEAK_BUDGET = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_FRAME   = 8192;

  localparam int LEN_W = 14;  // frame_length / peak position width
  localparam int IDX_W = 13;  // sample index within a frame
  localparam int TOT_W = 7;   // peak count width

  localparam logic [LEN_W-1:0] FRAME_LEN_RESET = LEN_W'(6001);

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic {
    RESULT_PEAK    = 1'b0,
    RESULT_SUMMARY = 1'b1
  } result_kind_t;

  typedef struct packed {
    result_kind_t      kind;
    logic [LEN_W-1:0]  location;
    logic [TOT_W-1:0]  total;
    logic              last;
  } result_t;

endpackage

@@ rtl/swpp_cell.sv @@
module swpp_cell
  import swpp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    shift_en,
  input  logic    clear,
  input  sample_t corr_in,
  input  sample_t thr_in,
  input  sample_t mid,
  output sample_t corr_q,
  output sample_t thr_q,
  output logic    beats_mid
);

  sample_t corr_r, corr_nxt;
  sample_t thr_r, thr_nxt;

  always_comb begin
    corr_nxt = corr_r;
    thr_nxt  = thr_r;
    if (clear) begin
      corr_nxt = '0;
      thr_nxt  = '0;
    end else if (shift_en) begin
      corr_nxt = corr_in;
      thr_nxt  = thr_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corr_r <= '0;
      thr_r  <= '0;
    end else begin
      corr_r <= corr_nxt;
      thr_r  <= thr_nxt;
    end
  end

  assign corr_q    = corr_r;
  assign thr_q     = thr_r;
  // a tie with the candidate also kills the peak
  assign beats_mid = (corr_r >= mid);

endmodule

@@ rtl/swpp_result_fifo.sv @@
module swpp_result_fifo
  import swpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] wr_cnt,
  input  result_t    wr_data0,
  input  result_t    wr_data1,
  input  logic       rd_en,
  output result_t    rd_data,
  output logic       empty,
  output logic       almost_full
);

  result_t mem_r [FIFO_DEPTH];

  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(wr_cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(rd_en);
    count_nxt  = count_r + FIFO_CNT_W'(wr_cnt) - FIFO_CNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= wr_data0;
    end
    if (wr_cnt == 2'd2) begin
      mem_r[wr_ptr_r + FIFO_PTR_W'(1)] <= wr_data1;
    end
  end

  assign rd_data     = mem_r[rd_ptr_r];
  assign empty       = (count_r == '0);
  // room for two entries is kept so both records of one transfer can always land
  assign almost_full = (count_r > FIFO_CNT_W'(FIFO_DEPTH - 2));

endmodule

@@ rtl/sliding_window_peak_picker.sv @@
// Sliding-window peak picker.
// Input channel (in_valid / in_stall): one correlation sample and its threshold
// per transfer, both signed. A transfer happens when valid is high and stall low.
// Output channel (out_valid / out_stall): result records. A peak report carries
// the 1-based frame position of the peak; an end-of-frame summary carries the
// number of peaks reported (at most PEAK_BUDGET). out_last_result marks the final
// record caused by one input transfer.
// Config: cfg_wr_en / cfg_wr_data set the frame length (0 acts as 1, values
// above MAX_FRAME saturate). Write it only while the block is idle.
// Results of an input transfer are registered in the result queue and leave
// it behind any earlier records. Throughput: one input transfer per cycle
// while in_stall is low. A frame-end sample that is also a peak yields two
// records, leaving the 4-entry result queue one per cycle while out_stall is low.
// Receiver stall: records pile up in the queue; in_stall rises once fewer than
// two queue slots are free, so nothing is ever dropped.
// Reset (rst_n, synchronous, active low): window, counters and queue cleared,
// frame length back to 6001.
module sliding_window_peak_picker
  import swpp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input samples
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_correlation_sample,
  input  logic [SAMPLE_BITS-1:0] in_threshold_sample,
  // results
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_result_kind,
  output logic [LEN_W-1:0]       out_peak_pos,
  output logic [TOT_W-1:0]       out_peak_total,
  output logic                   out_last_result,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [LEN_W-1:0]       cfg_wr_data
);

  localparam int NCELLS = WINDOW - 1;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] frame_length_r, frame_length_nxt;
  logic [IDX_W-1:0] sample_index_r, sample_index_nxt;
  logic [TOT_W-1:0] peaks_found_r, peaks_found_nxt;

  logic    in_xfer;
  logic    fifo_empty, fifo_almost_full;
  result_t fifo_rd_data;

  assign in_stall = fifo_almost_full;
  assign in_xfer  = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Cell row: cell j holds the sample j+1 places behind the incoming one. The
  // incoming sample is window entry 0, so the row holds entries 1..WINDOW-1.
  // ---------------------------------------------------------------------------
  sample_t corr_in, thr_in, mid;
  sample_t cell_corr [NCELLS];
  sample_t cell_thr  [NCELLS];
  logic    cell_beats [NCELLS];
  logic    frame_end;
  logic    clear_row;

  assign corr_in   = sample_t'(in_correlation_sample);
  assign thr_in    = sample_t'(in_threshold_sample);
  assign mid       = cell_corr[MIDDLE-1];  // window entry MIDDLE after the shift
  assign clear_row = in_xfer && frame_end;

  for (genvar j = 0; j < NCELLS; j++) begin : g_cell
    swpp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (in_xfer),
      .clear     (clear_row),
      .corr_in   ((j == 0) ? corr_in : cell_corr[(j == 0) ? 0 : j-1]),
      .thr_in    ((j == 0) ? thr_in  : cell_thr[(j == 0) ? 0 : j-1]),
      .mid       (mid),
      .corr_q    (cell_corr[j]),
      .thr_q     (cell_thr[j]),
      .beats_mid (cell_beats[j])
    );
  end

  // ---------------------------------------------------------------------------
  // Peak decision on the window as it stands after this sample
  // ---------------------------------------------------------------------------
  logic             beaten;
  logic             is_peak;
  logic             window_full;
  logic             peak_emit;
  logic [LEN_W-1:0] eff_length;
  logic [LEN_W-1:0] taken;
  logic [LEN_W-1:0] peak_loc;
  logic [TOT_W-1:0] peak_total;

  always_comb begin
    beaten = (corr_in >= mid);
    for (int j = 0; j < NCELLS; j++) begin
      if (j != MIDDLE - 1 && cell_beats[j]) begin
        beaten = 1'b1;
      end
    end
  end

  assign is_peak     = (mid > cell_thr[MIDDLE-1]) && !beaten;
  assign window_full = (sample_index_r >= IDX_W'(WINDOW - 1));
  assign peak_emit   = window_full && is_peak && (peaks_found_r < TOT_W'(PEAK_BUDGET));
  assign peak_loc    = LEN_W'(sample_index_r) - LEN_W'(MIDDLE) + LEN_W'(1);
  assign peak_total  = peaks_found_r + TOT_W'(peak_emit);

  always_comb begin
    eff_length = frame_length_r;
    if (frame_length_r == '0) begin
      eff_length = LEN_W'(1);
    end else if (frame_length_r > LEN_W'(MAX_FRAME)) begin
      eff_length = LEN_W'(MAX_FRAME);
    end
  end

  assign taken     = LEN_W'(sample_index_r) + LEN_W'(1);
  assign frame_end = (taken >= eff_length);

  // ---------------------------------------------------------------------------
  // Counters and config register
  // ---------------------------------------------------------------------------
  always_comb begin
    frame_length_nxt = frame_length_r;
    sample_index_nxt = sample_index_r;
    peaks_found_nxt  = peaks_found_r;
    if (cfg_wr_en) begin
      frame_length_nxt = cfg_wr_data;
    end
    if (in_xfer) begin
      if (frame_end) begin
        sample_index_nxt = '0;
        peaks_found_nxt  = '0;
      end else begin
        sample_index_nxt = sample_index_r + IDX_W'(1);
        peaks_found_nxt  = peak_total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= FRAME_LEN_RESET;
      sample_index_r <= '0;
      peaks_found_r  <= '0;
    end else begin
      frame_length_r <= frame_length_nxt;
      sample_index_r <= sample_index_nxt;
      peaks_found_r  <= peaks_found_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result records into the queue: peak report first, then the summary
  // ---------------------------------------------------------------------------
  result_t    rec_peak, rec_sum, wr_data0, wr_data1;
  logic [1:0] wr_cnt;

  always_comb begin
    rec_peak.kind     = RESULT_PEAK;
    rec_peak.location = peak_loc;
    rec_peak.total    = '0;
    rec_peak.last     = !frame_end;

    rec_sum.kind      = RESULT_SUMMARY;
    rec_sum.location  = '0;
    rec_sum.total     = peak_total;
    rec_sum.last      = 1'b1;

    wr_data0 = peak_emit ? rec_peak : rec_sum;
    wr_data1 = rec_sum;
    wr_cnt   = 2'd0;
    if (in_xfer) begin
      wr_cnt = 2'(peak_emit) + 2'(frame_end);
    end
  end

  swpp_result_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_cnt      (wr_cnt),
    .wr_data0    (wr_data0),
    .wr_data1    (wr_data1),
    .rd_en       (out_valid && !out_stall),
    .rd_data     (fifo_rd_data),
    .empty       (fifo_empty),
    .almost_full (fifo_almost_full)
  );

  assign out_valid       = !fifo_empty;
  assign out_result_kind = fifo_rd_data.kind;
  assign out_peak_pos    = fifo_rd_data.location;
  assign out_peak_total  = fifo_rd_data.total;
  assign out_last_result = fifo_rd_data.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_peak_budget: assert property (@(posedge clk) disable iff (!rst_n)
    peaks_found_r <= TOT_W'(PEAK_BUDGET))
    else $error("peak count above budget");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && frame_end |=> sample_index_r == '0 && peaks_found_r == '0)
    else $error("frame state not cleared after summary");

  a_peak_loc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RESULT_PEAK |-> out_peak_pos != '0)
    else $error("peak report with zero location");

  a_peak_not_last_midframe: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && peak_emit && !frame_end |-> window_full)
    else $error("peak reported before window filled");

endmodule
